/* rtl/core/lmfr_pkg.sv */
// Shared types and constants for the LED matrix frame refresh core.
// Used by every module under rtl/core; depends on nothing.
package lmfr_pkg;

  localparam int NUM_DISPLAYS_DEF  = 20;
  localparam int CHARS_PER_ROW_DEF = 20;

  // Character cell geometry
  localparam int NCOL         = 5;
  localparam int NROW         = 7;
  localparam int GAP_COLS     = 2;
  localparam int GAP_ROWS     = 8;
  localparam int CELL_PITCH_X = NCOL + GAP_COLS;
  localparam int CELL_PITCH_Y = NROW + GAP_ROWS;

  // Coordinate mapping: exact reciprocal multiply for 15-bit non-negative values
  localparam int              COORD_W = 15;
  localparam int              RECIP_W = 16;
  localparam int              PROD_W  = COORD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_X = 16'd37450;  // ceil(2^18 / 7)
  localparam int              SHIFT_X = 18;
  localparam logic [RECIP_W-1:0] RECIP_Y = 16'd34953;  // ceil(2^19 / 15)
  localparam int              SHIFT_Y = 19;
  localparam int              CQ_W    = 7;   // character column / row index
  localparam int              CELL_W  = 14;  // row * chars_per_row + column
  localparam int              ADDR_W  = 10;  // covers 5 * 4 * 32 entries

  localparam int DOT_W    = 3;
  localparam int COL_W    = 3;
  localparam int CHAR_W   = 7;
  localparam int DRV_W    = 5;
  localparam int CNT_W    = 16;

  // Configuration port
  localparam int                CFG_IW        = 1;
  localparam int                CFG_DW        = 16;
  localparam logic [CFG_IW-1:0] REG_ON_TICKS  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_OFF_TICKS = 1'b1;
  localparam logic [CFG_DW-1:0] ON_TICKS_RST  = 16'd254;
  localparam logic [CFG_DW-1:0] OFF_TICKS_RST = 16'd1;

  localparam int QDEPTH = 8;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_PIXEL = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_SWAP  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic              pixel_on;
    logic              wr_ok;
    logic [DOT_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

endpackage

/* rtl/core/lmfr_front.sv */
// Front end: takes command beats and maps pixel coordinates onto frame store entries.
// Two register stages; depends on lmfr_pkg.
module lmfr_front #(
  parameter int NUM_DISPLAYS  = lmfr_pkg::NUM_DISPLAYS_DEF,
  parameter int CHARS_PER_ROW = lmfr_pkg::CHARS_PER_ROW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  lmfr_pkg::mode_t     mode,
  input  logic signed [15:0]  pixel_x,
  input  logic signed [15:0]  pixel_y,
  input  logic                pixel_on,
  output logic                push,
  output lmfr_pkg::cmd_t      push_cmd,
  output logic [1:0]          inflight
);
  import lmfr_pkg::*;

  localparam int NCHR  = NUM_DISPLAYS * 4;
  localparam int SCR_W = CELL_PITCH_X * CHARS_PER_ROW - GAP_COLS;
  localparam int SCR_H = CELL_PITCH_Y * (NCHR / CHARS_PER_ROW) - GAP_ROWS;

  logic                s1_v_r;
  mode_t               s1_mode_r;
  logic                s1_on_r;
  logic                s1_ok_r;
  logic [2:0]          s1_x_r;
  logic [3:0]          s1_y_r;
  logic [PROD_W-1:0]   s1_xp_r;
  logic [PROD_W-1:0]   s1_yp_r;

  logic                s2_v_r;
  mode_t               s2_mode_r;
  logic                s2_on_r;
  logic                s2_ok_r;
  logic [2:0]          s2_col_r;
  logic [DOT_W-1:0]    s2_row_r;
  logic [CELL_W-1:0]   s2_cell_r;

  logic                in_range;
  logic [CQ_W-1:0]     qx;
  logic [CQ_W-1:0]     qy;
  logic [2:0]          rx;
  logic [3:0]          ry;
  logic                gap_ok;
  logic [CELL_W-1:0]   cell_nxt;

  assign in_range = !pixel_x[15] && (int'(pixel_x) < SCR_W) &&
                    !pixel_y[15] && (int'(pixel_y) < SCR_H);

  // Quotient bits come straight from the product; remainder mod 8/16 only
  // needs the low quotient bits since r = v - 8q + q (or v - 16q + q).
  assign qx       = s1_xp_r[SHIFT_X +: CQ_W];
  assign qy       = s1_yp_r[SHIFT_Y +: CQ_W];
  assign rx       = 3'(s1_x_r + s1_xp_r[SHIFT_X +: 3]);
  assign ry       = 4'(s1_y_r + s1_yp_r[SHIFT_Y +: 4]);
  assign gap_ok   = (int'(rx) < NCOL) && (int'(ry) < NROW);
  assign cell_nxt = CELL_W'(int'(qy) * CHARS_PER_ROW + int'(qx));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r <= mode;
      s1_on_r   <= pixel_on;
      s1_ok_r   <= in_range;
      s1_x_r    <= pixel_x[2:0];
      s1_y_r    <= pixel_y[3:0];
      s1_xp_r   <= PROD_W'(pixel_x[COORD_W-1:0]) * PROD_W'(RECIP_X);
      s1_yp_r   <= PROD_W'(pixel_y[COORD_W-1:0]) * PROD_W'(RECIP_Y);
    end
    s2_mode_r <= s1_mode_r;
    s2_on_r   <= s1_on_r;
    s2_ok_r   <= s1_ok_r && gap_ok;
    s2_col_r  <= rx;
    s2_row_r  <= ry[DOT_W-1:0];
    s2_cell_r <= cell_nxt;
  end

  // Chain position counts from the far end: last character is entry 0.
  always_comb begin
    push_cmd.mode     = s2_mode_r;
    push_cmd.pixel_on = s2_on_r;
    push_cmd.wr_ok    = s2_ok_r && (int'(s2_cell_r) < NCHR);
    push_cmd.row      = s2_row_r;
    push_cmd.addr     = ADDR_W'(int'(s2_col_r) * NCHR + (NCHR - 1) - int'(s2_cell_r));
  end

  assign push     = s2_v_r;
  assign inflight = {1'b0, s1_v_r} + {1'b0, s2_v_r};

endmodule

/* rtl/core/lmfr_queue.sv */
// Command queue between front end and scan back end.
// Small register FIFO of cmd_t entries; depends on lmfr_pkg.
module lmfr_queue #(
  parameter int DEPTH = lmfr_pkg::QDEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  lmfr_pkg::cmd_t               push_cmd,
  input  logic                         pop,
  output lmfr_pkg::cmd_t               pop_cmd,
  output logic                         not_empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import lmfr_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t            q_mem_r [DEPTH];
  logic [IW-1:0]   wr_ptr_r;
  logic [IW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign pop_cmd   = q_mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

/* rtl/core/lmfr_back.sv */
// Back end: column scan sequencer, double-buffered frame store, clear sweep.
// Execute stage issues memory reads, result stage merges data and writes back.
// Depends on lmfr_pkg.
module lmfr_back #(
  parameter int NUM_DISPLAYS = lmfr_pkg::NUM_DISPLAYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  lmfr_pkg::cmd_t                cmd,
  output logic                          pop,
  output logic                          init_busy,
  input  logic                          cfg_we,
  input  logic [lmfr_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [lmfr_pkg::CFG_DW-1:0]   cfg_wdata,
  output logic                          out_valid,
  output logic                          out_serial_data,
  output logic                          out_shift_valid,
  output logic [lmfr_pkg::DRV_W-1:0]    out_column_drive,
  output logic                          out_frame_done
);
  import lmfr_pkg::*;

  localparam int NCHR    = NUM_DISPLAYS * 4;
  localparam int BUF_LEN = NCOL * NCHR;
  localparam int AW      = $clog2(BUF_LEN);

  typedef enum logic [1:0] {
    PH_SHIFT,
    PH_ON,
    PH_OFF
  } phase_t;

  // scan state
  phase_t              phase_r, phase_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic [DOT_W-1:0]    dot_r, dot_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                front_sel_r, front_sel_nxt;
  logic                swap_pend_r, swap_pend_nxt;
  logic [CFG_DW-1:0]   on_ticks_r;
  logic [CFG_DW-1:0]   off_ticks_r;

  // clear sweep
  logic                sweep_act_r;
  logic                sweep_init_r;
  logic                sweep_bank_r;
  logic [AW-1:0]       sweep_addr_r;

  // result stage
  logic                w_v_r;
  logic                w_shift_r;
  logic [DOT_W-1:0]    w_dot_r;
  logic [DRV_W-1:0]    w_drive_r;
  logic                w_done_r;
  logic                w_wr_r;
  logic                w_on_r;
  logic [DOT_W-1:0]    w_row_r;
  logic [AW-1:0]       w_addr_r;
  logic                w_bank_r;
  logic                w_fwd_r;
  logic [NROW-1:0]     fwd_data_r;

  // frame store, one array per buffer
  logic [NROW-1:0]     mem0_r [BUF_LEN];
  logic [NROW-1:0]     mem1_r [BUF_LEN];
  logic [NROW-1:0]     rd0_r;
  logic [NROW-1:0]     rd1_r;

  // execute stage
  logic                e_rd;
  logic                e_rd_bank;
  logic [AW-1:0]       e_rd_addr;
  logic                e_wr;
  logic                e_shift;
  logic                e_done;
  logic                e_clear;
  logic                e_hit;
  logic                end_col;
  logic [DRV_W-1:0]    drive_now;
  logic [DRV_W-1:0]    e_drive;
  logic [CFG_DW-1:0]   on_len;
  logic [CNT_W:0]      cnt_inc;

  logic [NROW-1:0]     rdat;
  logic [NROW-1:0]     row_mask;
  logic [NROW-1:0]     pix_new;
  logic                wr_en0;
  logic                wr_en1;
  logic [AW-1:0]       wr_addr;
  logic [NROW-1:0]     wr_data;

  assign pop       = cmd_valid && !sweep_act_r;
  assign init_busy = sweep_init_r;

  assign drive_now = (phase_r == PH_ON) ? ~(DRV_W'(1) << col_r) : '1;
  assign on_len    = (on_ticks_r == '0) ? CFG_DW'(1) : on_ticks_r;
  assign cnt_inc   = {1'b0, cnt_r} + 1'b1;

  always_comb begin
    phase_nxt     = phase_r;
    col_nxt       = col_r;
    char_nxt      = char_r;
    dot_nxt       = dot_r;
    cnt_nxt       = cnt_r;
    front_sel_nxt = front_sel_r;
    swap_pend_nxt = swap_pend_r;
    e_rd          = 1'b0;
    e_rd_bank     = front_sel_r;
    e_rd_addr     = cmd.addr[AW-1:0];
    e_wr          = 1'b0;
    e_shift       = 1'b0;
    e_done        = 1'b0;
    e_clear       = 1'b0;
    end_col       = 1'b0;
    e_drive       = drive_now;
    if (pop) begin
      unique case (cmd.mode)
        MODE_TICK: begin
          unique case (phase_r)
            PH_SHIFT: begin
              e_rd      = 1'b1;
              e_shift   = 1'b1;
              e_rd_addr = AW'(int'(col_r) * NCHR + int'(char_r));
              e_drive   = '1;
              if (dot_r == '0) begin
                dot_nxt = DOT_W'(NROW - 1);
                if (int'(char_r) + 1 >= NCHR) begin
                  char_nxt  = '0;
                  phase_nxt = PH_ON;
                  cnt_nxt   = '0;
                end else begin
                  char_nxt = char_r + 1'b1;
                end
              end else begin
                dot_nxt = dot_r - 1'b1;
              end
            end
            PH_ON: begin
              if (cnt_inc >= {1'b0, on_len}) begin
                if (off_ticks_r == '0) begin
                  end_col = 1'b1;
                end else begin
                  phase_nxt = PH_OFF;
                  cnt_nxt   = '0;
                end
              end else begin
                cnt_nxt = cnt_inc[CNT_W-1:0];
              end
            end
            PH_OFF: begin
              e_drive = '1;
              if (cnt_inc >= {1'b0, off_ticks_r}) begin
                end_col = 1'b1;
              end else begin
                cnt_nxt = cnt_inc[CNT_W-1:0];
              end
            end
            default: begin
              phase_nxt = PH_SHIFT;
            end
          endcase
        end
        MODE_PIXEL: begin
          if (cmd.wr_ok) begin
            e_rd      = 1'b1;
            e_wr      = 1'b1;
            e_rd_bank = ~front_sel_r;
          end
        end
        MODE_CLEAR: begin
          e_clear = 1'b1;
        end
        MODE_SWAP: begin
          swap_pend_nxt = 1'b1;
        end
        default: begin
          e_clear = 1'b0;
        end
      endcase
    end
    if (end_col) begin
      phase_nxt = PH_SHIFT;
      cnt_nxt   = '0;
      char_nxt  = '0;
      dot_nxt   = DOT_W'(NROW - 1);
      if (int'(col_r) >= NCOL - 1) begin
        col_nxt = '0;
        e_done  = 1'b1;
        if (swap_pend_r) begin
          front_sel_nxt = ~front_sel_r;
          swap_pend_nxt = 1'b0;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    // read-modify-write of the previous beat lands this cycle: forward it
    e_hit = e_rd && w_wr_r && (w_bank_r == e_rd_bank) && (w_addr_r == e_rd_addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SHIFT;
      col_r        <= '0;
      char_r       <= '0;
      dot_r        <= DOT_W'(NROW - 1);
      cnt_r        <= '0;
      front_sel_r  <= 1'b0;
      swap_pend_r  <= 1'b0;
      on_ticks_r   <= ON_TICKS_RST;
      off_ticks_r  <= OFF_TICKS_RST;
      sweep_act_r  <= 1'b1;
      sweep_init_r <= 1'b1;
      sweep_bank_r <= 1'b0;
      sweep_addr_r <= '0;
      w_v_r        <= 1'b0;
      w_shift_r    <= 1'b0;
      w_done_r     <= 1'b0;
      w_wr_r       <= 1'b0;
      w_fwd_r      <= 1'b0;
      w_drive_r    <= '1;
    end else begin
      phase_r     <= phase_nxt;
      col_r       <= col_nxt;
      char_r      <= char_nxt;
      dot_r       <= dot_nxt;
      cnt_r       <= cnt_nxt;
      front_sel_r <= front_sel_nxt;
      swap_pend_r <= swap_pend_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ON_TICKS:  on_ticks_r  <= cfg_wdata;
          REG_OFF_TICKS: off_ticks_r <= cfg_wdata;
        endcase
      end
      if (sweep_act_r) begin
        sweep_addr_r <= sweep_addr_r + 1'b1;
        if (int'(sweep_addr_r) == BUF_LEN - 1) begin
          sweep_act_r  <= 1'b0;
          sweep_init_r <= 1'b0;
        end
      end else if (e_clear) begin
        sweep_act_r  <= 1'b1;
        sweep_bank_r <= ~front_sel_r;
        sweep_addr_r <= '0;
      end
      w_v_r     <= pop;
      w_shift_r <= e_shift;
      w_done_r  <= e_done;
      w_wr_r    <= e_wr;
      w_fwd_r   <= e_hit;
      w_drive_r <= e_drive;
    end
  end

  always_ff @(posedge clk) begin
    w_dot_r    <= dot_r;
    w_on_r     <= cmd.pixel_on;
    w_row_r    <= cmd.row;
    w_addr_r   <= e_rd_addr;
    w_bank_r   <= e_rd_bank;
    fwd_data_r <= pix_new;
  end

  assign rdat     = w_fwd_r ? fwd_data_r : (w_bank_r ? rd1_r : rd0_r);
  assign row_mask = NROW'(1) << w_row_r;
  assign pix_new  = w_on_r ? (rdat | row_mask) : (rdat & ~row_mask);

  always_comb begin
    wr_addr = w_addr_r;
    wr_data = pix_new;
    wr_en0  = 1'b0;
    wr_en1  = 1'b0;
    priority if (sweep_act_r) begin
      wr_addr = sweep_addr_r;
      wr_data = '0;
      wr_en0  = sweep_init_r || !sweep_bank_r;
      wr_en1  = sweep_init_r || sweep_bank_r;
    end else if (w_wr_r) begin
      wr_en0 = !w_bank_r;
      wr_en1 = w_bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en0) begin
      mem0_r[wr_addr] <= wr_data;
    end
    if (wr_en1) begin
      mem1_r[wr_addr] <= wr_data;
    end
    rd0_r <= mem0_r[e_rd_addr];
    rd1_r <= mem1_r[e_rd_addr];
  end

  assign out_valid        = w_v_r;
  assign out_shift_valid  = w_shift_r;
  assign out_serial_data  = w_shift_r & rdat[w_dot_r];
  assign out_column_drive = w_drive_r;
  assign out_frame_done   = w_done_r;

endmodule

/* rtl/core/led_matrix_frame_refresh_core.sv */
// Top level of the LED matrix frame refresh core: front end, command queue, scan back end.
// Depends on lmfr_pkg, lmfr_front, lmfr_queue, lmfr_back.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------------------------------
//   command  | start && !busy              | in_mode, in_pixel_x, in_pixel_y, in_pixel_on
//   result   | out_valid, one cycle strobe | out_serial_data, out_shift_valid,
//            |                             | out_column_drive, out_frame_done
//   config   | cfg_we                      | cfg_index, cfg_wdata
//
// One command beat per cycle sustained while busy is low; every beat gives one result after
// passing the two front stages, the queue and the result stage. A clear holds the back end
// while it zeroes the back buffer; busy rises once beats in the queue plus beats in the two front
// stages reach 8. After reset busy stays high while both buffers are zeroed.
// Results cannot be held off; reset is synchronous and active low.
module led_matrix_frame_refresh_core #(
  parameter int NUM_DISPLAYS  = lmfr_pkg::NUM_DISPLAYS_DEF,
  parameter int CHARS_PER_ROW = lmfr_pkg::CHARS_PER_ROW_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_mode,
  input  logic signed [15:0]            in_pixel_x,
  input  logic signed [15:0]            in_pixel_y,
  input  logic                          in_pixel_on,
  output logic                          out_valid,
  output logic                          out_serial_data,
  output logic                          out_shift_valid,
  output logic [lmfr_pkg::DRV_W-1:0]    out_column_drive,
  output logic                          out_frame_done,
  input  logic                          cfg_we,
  input  logic [lmfr_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [lmfr_pkg::CFG_DW-1:0]   cfg_wdata
);
  import lmfr_pkg::*;

  localparam int QCW = $clog2(QDEPTH + 1);

  logic            accept;
  logic            push;
  cmd_t            push_cmd;
  logic [1:0]      inflight;
  logic            pop;
  cmd_t            pop_cmd;
  logic            q_not_empty;
  logic [QCW-1:0]  q_count;
  logic            init_busy;

  // credit check: every beat already in the front stages must find a queue slot
  assign busy   = init_busy || (int'(q_count) + int'(inflight) >= QDEPTH);
  assign accept = start && !busy;

  lmfr_front #(
    .NUM_DISPLAYS  (NUM_DISPLAYS),
    .CHARS_PER_ROW (CHARS_PER_ROW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .mode     (mode_t'(in_mode)),
    .pixel_x  (in_pixel_x),
    .pixel_y  (in_pixel_y),
    .pixel_on (in_pixel_on),
    .push     (push),
    .push_cmd (push_cmd),
    .inflight (inflight)
  );

  lmfr_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  lmfr_back #(
    .NUM_DISPLAYS (NUM_DISPLAYS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (q_not_empty),
    .cmd              (pop_cmd),
    .pop              (pop),
    .init_busy        (init_busy),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_serial_data  (out_serial_data),
    .out_shift_valid  (out_shift_valid),
    .out_column_drive (out_column_drive),
    .out_frame_done   (out_frame_done)
  );

endmodule

/* sim/led_matrix_frame_refresh_core_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for led_matrix_frame_refresh_core: queued command beats, scan prediction.
// Depends on lmfr_pkg and the core RTL.
module led_matrix_frame_refresh_core_test;
  import lmfr_pkg::*;

  localparam int DISPLAYS     = 20;
  localparam int ROW_CHARS    = 20;
  localparam int CHARS        = DISPLAYS * 4;
  localparam int BUF_LEN      = NCOL * CHARS;
  localparam int SCR_W        = CELL_PITCH_X * ROW_CHARS - GAP_COLS;
  localparam int SCR_H        = CELL_PITCH_Y * (CHARS / ROW_CHARS) - GAP_ROWS;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 40;

  typedef enum logic [1:0] {SCAN_SHIFT, SCAN_ON, SCAN_OFF} scan_phase_e;

  typedef struct packed {
    mode_t              mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               lit;
  } cmd_beat_t;

  typedef struct packed {
    logic             sdata;
    logic             shifting;
    logic [DRV_W-1:0] drive;
    logic             done;
  } scan_beat_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_mode;
  logic signed [15:0] in_pixel_x;
  logic signed [15:0] in_pixel_y;
  logic               in_pixel_on;
  logic               out_valid;
  logic               out_serial_data;
  logic               out_shift_valid;
  logic [DRV_W-1:0]   out_column_drive;
  logic               out_frame_done;
  logic               cfg_we;
  logic [CFG_IW-1:0]  cfg_index;
  logic [CFG_DW-1:0]  cfg_wdata;

  led_matrix_frame_refresh_core #(
    .NUM_DISPLAYS (DISPLAYS),
    .CHARS_PER_ROW(ROW_CHARS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_pixel_on     (in_pixel_on),
    .out_valid       (out_valid),
    .out_serial_data (out_serial_data),
    .out_shift_valid (out_shift_valid),
    .out_column_drive(out_column_drive),
    .out_frame_done  (out_frame_done),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  cmd_beat_t   pending_cmds[$];
  scan_beat_t  expected_scan[$];
  bit          steady_run;

  // Display model: both frame buffers, scan position, timing registers
  logic [NROW-1:0] dots[0:2*BUF_LEN-1];
  logic            shown_buf;
  logic            swap_req;
  scan_phase_e     phase;
  int              col_idx;
  int              char_idx;
  int              dot_idx;
  int              phase_cnt;
  int              on_len_reg;
  int              off_len_reg;

  int beats_in;
  int results_checked;
  int mismatches;
  int frames;
  int swaps;
  int pixels_landed;
  int clears;
  int stall_cnt;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void reset_display_model();
    foreach (dots[i]) dots[i] = '0;
    shown_buf   = 1'b0;
    swap_req    = 1'b0;
    phase       = SCAN_SHIFT;
    col_idx     = 0;
    char_idx    = 0;
    dot_idx     = 6;
    phase_cnt   = 0;
    on_len_reg  = ON_TICKS_RST;
    off_len_reg = OFF_TICKS_RST;
  endfunction

  function automatic logic [DRV_W-1:0] drive_now();
    logic [DRV_W-1:0] d;
    d = '1;
    if (phase == SCAN_ON) d[col_idx] = 1'b0;
    return d;
  endfunction

  // Returns 1 when the column just closed was the last of the frame.
  function automatic logic close_column();
    phase     = SCAN_SHIFT;
    phase_cnt = 0;
    char_idx  = 0;
    dot_idx   = 6;
    if (col_idx >= NCOL - 1) begin
      col_idx = 0;
      frames++;
      if (swap_req) begin
        shown_buf = ~shown_buf;
        swap_req  = 1'b0;
        swaps++;
      end
      return 1'b1;
    end
    col_idx++;
    return 1'b0;
  endfunction

  function automatic scan_beat_t step_scan();
    scan_beat_t      r;
    logic [NROW-1:0] v;
    int              on_len;
    r       = '0;
    r.drive = '1;
    on_len  = (on_len_reg == 0) ? 1 : on_len_reg;
    case (phase)
      SCAN_SHIFT: begin
        v          = dots[(shown_buf ? BUF_LEN : 0) + col_idx * CHARS + char_idx];
        r.sdata    = v[dot_idx];
        r.shifting = 1'b1;
        if (dot_idx == 0) begin
          dot_idx = 6;
          if (char_idx + 1 >= CHARS) begin
            char_idx  = 0;
            phase     = SCAN_ON;
            phase_cnt = 0;
          end else begin
            char_idx++;
          end
        end else begin
          dot_idx--;
        end
      end
      SCAN_ON: begin
        r.drive = drive_now();
        if (phase_cnt + 1 >= on_len) begin
          if (off_len_reg == 0) begin
            r.done = close_column();
          end else begin
            phase     = SCAN_OFF;
            phase_cnt = 0;
          end
        end else begin
          phase_cnt++;
        end
      end
      default: begin
        if (phase_cnt + 1 >= off_len_reg) r.done = close_column();
        else phase_cnt++;
      end
    endcase
    return r;
  endfunction

  // Screen is split into 5x7 cells with hidden gap columns/rows between them.
  function automatic void write_pixel(int x, int y, logic lit);
    int ccol;
    int crow;
    int pos;
    int idx;
    if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H) return;
    ccol = x % CELL_PITCH_X;
    crow = y % CELL_PITCH_Y;
    if (ccol >= NCOL || crow >= NROW) return;
    pos = CHARS - ((y / CELL_PITCH_Y) * ROW_CHARS + x / CELL_PITCH_X) - 1;
    idx = (shown_buf ? 0 : BUF_LEN) + ccol * CHARS + pos;
    dots[idx][crow] = lit;
    pixels_landed++;
  endfunction

  function automatic scan_beat_t predict_scan(cmd_beat_t c);
    scan_beat_t r;
    int         base;
    if (c.mode == MODE_TICK) return step_scan();
    case (c.mode)
      MODE_PIXEL: write_pixel(int'(c.x), int'(c.y), c.lit);
      MODE_CLEAR: begin
        base = shown_buf ? 0 : BUF_LEN;
        for (int i = 0; i < BUF_LEN; i++) dots[base + i] = '0;
        clears++;
      end
      default: swap_req = 1'b1;
    endcase
    r       = '0;
    r.drive = drive_now();
    return r;
  endfunction

  function automatic cmd_beat_t rand_cmd(int tick_pct);
    cmd_beat_t c;
    int        sel;
    int        t;
    c.x   = 16'($urandom);
    c.y   = 16'($urandom);
    c.lit = 1'($urandom_range(1));
    if ($urandom_range(99) < tick_pct) begin
      c.mode = MODE_TICK;
    end else begin
      sel = $urandom_range(99);
      if (sel < 78) begin
        c.mode = MODE_PIXEL;
        sel    = $urandom_range(99);
        if (sel < 60) begin
          c.x = 16'($urandom_range(SCR_W - 1));
          c.y = 16'($urandom_range(SCR_H - 1));
        end else if (sel < 80) begin
          // hug the screen border from both sides
          t   = int'($urandom_range(SCR_W + 5)) - 3;
          c.x = 16'(t);
          t   = int'($urandom_range(SCR_H + 5)) - 3;
          c.y = 16'(t);
        end
      end else if (sel < 95) begin
        c.mode = MODE_SWAP;
      end else begin
        c.mode = MODE_CLEAR;
      end
    end
    return c;
  endfunction

  function automatic void check_field(string what, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
    end
  endfunction

  task automatic add_cmd(mode_t m, int x, int y, logic lit);
    cmd_beat_t c;
    c.mode = m;
    c.x    = 16'(x);
    c.y    = 16'(y);
    c.lit  = lit;
    pending_cmds.push_back(c);
  endtask

  task automatic set_reg(logic [CFG_IW-1:0] idx, int val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_DW'(val);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk); while (pending_cmds.size() != 0 || expected_scan.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(int on_v, int off_v, int n, int tick_pct, bit steady);
    settle();
    set_reg(REG_ON_TICKS, on_v);
    set_reg(REG_OFF_TICKS, off_v);
    @(posedge clk);
    steady_run = steady;
    repeat (n) pending_cmds.push_back(rand_cmd(tick_pct));
  endtask

  // Driver: the oldest pending beat is offered at each falling edge unless this cycle idles.
  always @(negedge clk) begin
    if (pending_cmds.size() != 0 && (steady_run || $urandom_range(99) >= 23)) begin
      start       <= 1'b1;
      in_mode     <= pending_cmds[0].mode;
      in_pixel_x  <= pending_cmds[0].x;
      in_pixel_y  <= pending_cmds[0].y;
      in_pixel_on <= pending_cmds[0].lit;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: register writes and accepted beats feed the model, results are checked.
  always @(posedge clk) begin
    cmd_beat_t  cur;
    scan_beat_t want;
    scan_beat_t got;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == REG_ON_TICKS) on_len_reg = int'(cfg_wdata);
        else off_len_reg = int'(cfg_wdata);
      end
      if (start && !busy) begin
        cur.mode = mode_t'(in_mode);
        cur.x    = in_pixel_x;
        cur.y    = in_pixel_y;
        cur.lit  = in_pixel_on;
        expected_scan.push_back(predict_scan(cur));
        void'(pending_cmds.pop_front());
        beats_in++;
      end
      if (out_valid) begin
        got = {out_serial_data, out_shift_valid, out_column_drive, out_frame_done};
        if (expected_scan.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected, expected none, actual %b",
                     $time, got);
        end else begin
          want = expected_scan.pop_front();
          results_checked++;
          check_field("serial_data", want.sdata, got.sdata);
          check_field("shift_valid", want.shifting, got.shifting);
          check_field("column_drive", want.drive, got.drive);
          check_field("frame_done", want.done, got.done);
        end
      end
      if ((start && !busy) || out_valid) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_mode     = MODE_TICK;
    in_pixel_x  = '0;
    in_pixel_y  = '0;
    in_pixel_on = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_ON_TICKS;
    cfg_wdata   = '0;
    steady_run  = 1'b0;
    reset_display_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats on the reset timing: corners, gaps, off-screen, clear, double swap
    @(posedge clk);
    add_cmd(MODE_TICK, 0, 0, 1'b0);
    add_cmd(MODE_PIXEL, 0, 0, 1'b1);
    add_cmd(MODE_PIXEL, SCR_W - 1, SCR_H - 1, 1'b1);
    add_cmd(MODE_PIXEL, NCOL, 0, 1'b1);
    add_cmd(MODE_PIXEL, 0, NROW, 1'b1);
    add_cmd(MODE_PIXEL, -1, 0, 1'b1);
    add_cmd(MODE_PIXEL, SCR_W, 0, 1'b1);
    add_cmd(MODE_PIXEL, 0, SCR_H, 1'b1);
    add_cmd(MODE_PIXEL, -32768, -32768, 1'b1);
    add_cmd(MODE_PIXEL, 32767, 32767, 1'b0);
    add_cmd(MODE_PIXEL, 0, 0, 1'b0);
    add_cmd(MODE_CLEAR, -1, -1, 1'b1);
    add_cmd(MODE_PIXEL, 0, 0, 1'b1);
    add_cmd(MODE_PIXEL, NCOL - 1, NROW - 1, 1'b1);
    add_cmd(MODE_PIXEL, SCR_W - 1, SCR_H - 1, 1'b1);
    add_cmd(MODE_PIXEL, 70, 30, 1'b1);
    add_cmd(MODE_SWAP, 0, 0, 1'b0);
    add_cmd(MODE_SWAP, 0, 0, 1'b0);
    add_cmd(MODE_TICK, 0, 0, 1'b0);
    add_cmd(MODE_TICK, 0, 0, 1'b0);
    add_cmd(MODE_TICK, 0, 0, 1'b0);
    repeat (80) pending_cmds.push_back(rand_cmd(40));

    // Later phases change the timing registers between bursts and lean on ticks.
    run_phase(1, 0, 110, 93, 1'b1);
    run_phase(0, 2, 90, 92, 1'b0);
    run_phase(65535, 65535, 50, 95, 1'b0);
    run_phase(3, 65535, 40, 95, 1'b0);
    run_phase(300, 4, 60, 93, 1'b0);
    run_phase(2, 1, 50, 88, 1'b0);
    settle();

    $display("%0d command beats, %0d result beats checked, %0d frames scanned, %0d swaps",
             beats_in, results_checked, frames, swaps);
    $display("%0d pixel writes landed, %0d back buffer clears, %0d mismatches",
             pixels_landed, clears, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
